### sv/max_heap_priority_queue_defines.svh
// Assertion macros for the max-heap priority queue.
// Included by the top level; depends on nothing else.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mhpq_pkg.sv
// Shared types, codes and defaults for the max-heap priority queue.
// No dependencies; imported by every module of the block.
package mhpq_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int TOTAL_W      = 9;

    // Operation codes carried in the func field.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Status codes reported with every response.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] item_value;
    } heap_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic [STATUS_W-1:0]      status;
        logic [TOTAL_W-1:0]       entry_total;
    } heap_out_t;

endpackage

### sv/mhpq_ram.sv
// Heap storage: one write port and two registered read ports.
// Uses mhpq_pkg for the data width.
module mhpq_ram #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic signed [mhpq_pkg::DATA_W-1:0] wr_data,
    input  logic [AW-1:0]                     rd_addr_a,
    input  logic [AW-1:0]                     rd_addr_b,
    output logic signed [mhpq_pkg::DATA_W-1:0] rd_data_a,
    output logic signed [mhpq_pkg::DATA_W-1:0] rd_data_b
);
    import mhpq_pkg::*;

    logic signed [DATA_W-1:0] mem [CAPACITY];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports, each registered.
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### sv/mhpq_engine.sv
// Heap controller: sift-up for insert and sift-down for delete over the heap RAM.
// Uses mhpq_pkg types and codes; drives mhpq_ram through its address and data ports.
module mhpq_engine #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  mhpq_pkg::heap_in_t                req_data,
    output logic                              done,
    output mhpq_pkg::heap_out_t               result,
    input  logic                              ack,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic signed [mhpq_pkg::DATA_W-1:0] wr_data,
    output logic [AW-1:0]                     rd_addr_a,
    output logic [AW-1:0]                     rd_addr_b,
    input  logic signed [mhpq_pkg::DATA_W-1:0] rd_data_a,
    input  logic signed [mhpq_pkg::DATA_W-1:0] rd_data_b
);
    import mhpq_pkg::*;

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CW1 = CW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_CMP = 3'd1;
    localparam logic [2:0] S_DEL_LD = 3'd2;
    localparam logic [2:0] S_DN_CMP = 3'd3;
    localparam logic [2:0] S_PUT    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] res_value_reg, res_value_next;
    logic [STATUS_W-1:0]      res_status_reg, res_status_next;

    logic [CW1-1:0]           count_ext;
    logic [AW-1:0]            ins_pos;
    logic [AW-1:0]            ins_parent;
    logic [AW-1:0]            up_parent;
    logic [AW-1:0]            up_grand;
    logic [CW1-1:0]           dn_left;
    logic [CW1-1:0]           dn_right;
    logic                     take_right;
    logic [AW-1:0]            pick_idx;
    logic signed [DATA_W-1:0] pick_val;
    logic [CW1-1:0]           nx_left;
    logic [CW1-1:0]           nx_right;
    logic [CW1-1:0]           root_left;
    logic [CW1-1:0]           root_right;

    // Index arithmetic for parents and children.
    always_comb
    begin
        count_ext  = CW1'(count_reg);
        ins_pos    = count_reg[AW-1:0];
        ins_parent = (ins_pos - AW'(1)) >> 1;
        up_parent  = (pos_reg - AW'(1)) >> 1;
        up_grand   = (up_parent - AW'(1)) >> 1;
        root_left  = CW1'(1);
        root_right = CW1'(2);
        dn_left    = CW1'({pos_reg, 1'b1});
        dn_right   = dn_left + CW1'(1);
        // Right child wins only when present and strictly larger.
        take_right = (dn_right < count_ext) && (rd_data_a < rd_data_b);
        pick_idx   = take_right ? dn_right[AW-1:0] : dn_left[AW-1:0];
        pick_val   = take_right ? rd_data_b : rd_data_a;
        nx_left    = CW1'({pick_idx, 1'b1});
        nx_right   = nx_left + CW1'(1);
    end

    // Sequencer: one tree level per cycle, the hole is written as the key moves.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = key_reg;
        rd_addr_a       = '0;
        rd_addr_b       = '0;
        req_ready       = (state_reg == S_IDLE);
        done            = (state_reg == S_DONE);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    if (req_data.func == FUNC_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            key_next   = req_data.item_value;
                            pos_next   = ins_pos;
                            count_next = count_reg + CW'(1);
                            if (count_reg == '0)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                rd_addr_a  = ins_parent;
                                state_next = S_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // Fetch the root and the last entry together.
                            rd_addr_a  = '0;
                            rd_addr_b  = ins_pos - AW'(1);
                            count_next = count_reg - CW'(1);
                            state_next = S_DEL_LD;
                        end
                    end
                end
            end

            S_UP_CMP:
            begin
                // Parent value is on port A; move it down if it is smaller.
                if (rd_data_a < key_reg)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data_a;
                    pos_next = up_parent;
                    if (up_parent == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        rd_addr_a = up_grand;
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_DEL_LD:
            begin
                res_value_next = rd_data_a;
                key_next       = rd_data_b;
                pos_next       = '0;
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (root_left < count_ext)
                begin
                    rd_addr_a  = root_left[AW-1:0];
                    rd_addr_b  = root_right[AW-1:0];
                    state_next = S_DN_CMP;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_DN_CMP:
            begin
                // Children of the hole are on ports A and B.
                if (key_reg < pick_val)
                begin
                    wr_en    = 1'b1;
                    wr_data  = pick_val;
                    pos_next = pick_idx;
                    if (nx_left < count_ext)
                    begin
                        rd_addr_a = nx_left[AW-1:0];
                        rd_addr_b = nx_right[AW-1:0];
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                wr_en      = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response payload.
    always_comb
    begin
        result.out_value   = res_value_reg;
        result.status      = res_status_reg;
        result.entry_total = TOTAL_W'(count_reg);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

endmodule

### sv/max_heap_priority_queue.sv
// Max-heap priority queue of signed 32-bit values.
// Channels: request (req_valid/req_ready/req_data) and response (rsp_valid/rsp_ready/rsp_data),
// both valid/ready; a transfer happens on a clock edge with valid and ready high.
// A request with func insert adds item_value; func delete removes and returns the maximum.
// Every request gives exactly one response with out_value, status and entry_total.
// Requests are processed one at a time. From acceptance until the response register
// loads, an insert climbs the tree level by level, then makes the final write and the
// handoff, and a delete fetches the root and the last entry, descends level by level,
// makes the final write (skipped when the heap becomes empty) and the handoff; the sift
// walks one tree level per cycle over the heap RAM, which has two registered read ports
// and one write port. The next request can be taken in the cycle after the response is
// loaded. Refused requests (insert when full, delete when empty) go straight to the handoff.
// Reset empties the heap at once; no clearing pass is needed, as only entries below
// the count are read. The response register lets a new request start while a response
// waits; when the receiver stalls, a second finished result waits inside the controller.
// Depends on mhpq_pkg, mhpq_engine, mhpq_ram and max_heap_priority_queue_defines.svh.
`include "max_heap_priority_queue_defines.svh"

module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  mhpq_pkg::heap_in_t   req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output mhpq_pkg::heap_out_t  rsp_data
);
    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                     eng_done;
    logic                     eng_ack;
    heap_out_t                eng_result;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [AW-1:0]            rd_addr_a;
    logic [AW-1:0]            rd_addr_b;
    logic signed [DATA_W-1:0] rd_data_a;
    logic signed [DATA_W-1:0] rd_data_b;

    logic                     rsp_valid_reg, rsp_valid_next;
    heap_out_t                rsp_data_reg, rsp_data_next;

    mhpq_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .done      (eng_done),
        .result    (eng_result),
        .ack       (eng_ack),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    mhpq_ram #(
        .CAPACITY (CAPACITY)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Response register: loads when empty or being drained this cycle.
    always_comb
    begin
        eng_ack        = eng_done && (!rsp_valid_reg || rsp_ready);
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;
        if (eng_ack)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = eng_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Checks on the controller and the response path.
    `MHPQ_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready, "request accepted while a previous one is in flight")
    `MHPQ_ASSERT_NEXT(a_result_held, clk, rst_n, eng_done && !eng_ack, eng_done && $stable(eng_result), "finished result lost while the response register was full")
    `MHPQ_ASSERT_NOW(a_empty_rsp, clk, rst_n, rsp_valid && (rsp_data.status == ST_EMPTY), (rsp_data.entry_total == '0) && (rsp_data.out_value == '0), "empty-heap response with nonzero count or value")
    `MHPQ_ASSERT_NOW(a_full_rsp, clk, rst_n, rsp_valid && (rsp_data.status == ST_FULL), rsp_data.out_value == '0, "full-heap response with nonzero value")

endmodule
